[rtl/assert_macros.svh]
// Assertion macros shared by the erfinv RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ERF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ERF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ERF_ASSERT(label, clk, rst_n, prop, msg)
`define ERF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[rtl/erfinv_pkg.sv]
// Package for the inverse error function pipeline: widths, coefficients
// and the data carried between cells. No dependencies.
package erfinv_pkg;

    localparam int IN_FRAC_BITS  = 23;
    localparam int OUT_FRAC_BITS = 20;
    localparam int IN_W   = IN_FRAC_BITS + 1;
    localparam int OUT_W  = OUT_FRAC_BITS + 3;
    localparam int WFB    = 28;                     // fraction bits of w, t and p
    localparam int D_W    = 2 * IN_FRAC_BITS + 1;   // (1-x)(1+x) in Q1.2F
    localparam int E_W    = $clog2(D_W);
    localparam int M_W    = 31;                     // log mantissa, Q1.30
    localparam int LOG_STEPS = WFB;
    localparam int V_W    = E_W + WFB;
    localparam int W_W    = V_W;
    localparam int R_W    = (W_W + WFB + 1) / 2;    // sqrt root width
    localparam int SQ_W   = 2 * R_W;
    localparam int T_W    = R_W + 1;
    localparam int P_W    = 36;
    localparam int HORNER_STEPS = 8;
    localparam int SH_OUT = WFB + IN_FRAC_BITS - OUT_FRAC_BITS;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic signed [P_W-1:0] COEF_LO [HORNER_STEPS+1] = '{
        36'sd403031520, 36'sd66207116, -36'sd1121438, -36'sd336544, 36'sd58675,
        -36'sd1179, -36'sd946, 36'sd92, 36'sd8
    };
    localparam logic signed [P_W-1:0] COEF_HI [HORNER_STEPS+1] = '{
        36'sd760471425, 36'sd268884833, 36'sd2533727, -36'sd2046139, 36'sd1540687,
        -36'sd986078, 36'sd362212, 36'sd27099, -36'sd53745
    };

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic                   zero;   // argument is exactly -1.0
    } front_t;

    typedef struct packed {
        logic [E_W-1:0] e;
        logic [M_W-1:0] m;
        logic [WFB-1:0] frac;
        front_t         front;
    } log_t;

    typedef struct packed {
        logic [SQ_W-1:0]        n;
        logic [R_W+1:0]         rem;
        logic [R_W-1:0]         root;
        logic                   hi;
        logic signed [T_W-1:0]  t_lo;
        front_t                 front;
    } sqrt_t;

    typedef struct packed {
        logic signed [P_W-1:0] p;
        logic signed [T_W-1:0] t;
        logic                  hi;
        front_t                front;
    } horner_t;

endpackage

[rtl/erfinv_if.sv]
// Valid/ready channel interfaces for the erfinv argument and result.
// Depends on erfinv_pkg.
interface erfinv_in_if;
    import erfinv_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] arg_x;
    modport source (output valid, output arg_x, input ready);
    modport sink (input valid, input arg_x, output ready);
endinterface

interface erfinv_out_if;
    import erfinv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] erfinv_value;
    logic                    saturated;
    modport source (output valid, output erfinv_value, output saturated, input ready);
    modport sink (input valid, input erfinv_value, input saturated, output ready);
endinterface

[rtl/erfinv_log_cell.sv]
// One squaring step of the base-2 logarithm: yields one fraction bit.
// Depends on erfinv_pkg.
module erfinv_log_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  erfinv_pkg::log_t  in_data,
    output logic              out_valid,
    output erfinv_pkg::log_t  out_data
);
    import erfinv_pkg::*;

    logic              out_valid_reg;
    log_t              out_data_reg;
    log_t              data_next;
    logic [2*M_W-1:0]  sq;
    logic [M_W:0]      msq;

    always_comb
    begin
        sq  = in_data.m * in_data.m;
        msq = sq[M_W-1 +: M_W+1];
        data_next       = in_data;
        data_next.m     = msq[M_W] ? msq[M_W:1] : msq[M_W-1:0];
        data_next.frac  = {in_data.frac[WFB-2:0], msq[M_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule

[rtl/erfinv_sqrt_cell.sv]
// One digit step of the integer square root: one root bit per cell.
// Depends on erfinv_pkg.
module erfinv_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  erfinv_pkg::sqrt_t  in_data,
    output logic               out_valid,
    output erfinv_pkg::sqrt_t  out_data
);
    import erfinv_pkg::*;

    logic           out_valid_reg;
    sqrt_t          out_data_reg;
    sqrt_t          data_next;
    logic [R_W+2:0] rem2;
    logic [R_W+2:0] trial;
    logic           ge;

    always_comb
    begin
        rem2  = {in_data.rem[R_W:0], in_data.n[SQ_W-1 -: 2]};
        trial = {1'b0, in_data.root, 2'b01};
        ge    = rem2 >= trial;
        data_next      = in_data;
        data_next.n    = {in_data.n[SQ_W-3:0], 2'b00};
        data_next.rem  = ge ? (R_W+2)'(rem2 - trial) : rem2[R_W+1:0];
        data_next.root = {in_data.root[R_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule

[rtl/erfinv_horner_cell.sv]
// One Horner step: p = c + round(p * t / 2^WFB), coefficient set picked per item.
// Depends on erfinv_pkg.
module erfinv_horner_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic signed [erfinv_pkg::P_W-1:0]   c_lo,
    input  logic signed [erfinv_pkg::P_W-1:0]   c_hi,
    input  logic                                in_valid,
    input  erfinv_pkg::horner_t                 in_data,
    output logic                                out_valid,
    output erfinv_pkg::horner_t                 out_data
);
    import erfinv_pkg::*;

    localparam int PT_W = P_W + T_W;
    localparam logic signed [PT_W-1:0] RND = PT_W'(1) <<< (WFB - 1);

    logic                   out_valid_reg;
    horner_t                out_data_reg;
    horner_t                data_next;
    logic signed [PT_W-1:0] prod;
    logic signed [PT_W-1:0] adj;
    logic signed [PT_W-1:0] shifted;

    always_comb
    begin
        prod    = in_data.p * in_data.t;
        // halves away from zero: bias negatives down by one
        adj     = prod + RND - $signed({{(PT_W-1){1'b0}}, prod[PT_W-1]});
        shifted = adj >>> WFB;
        data_next   = in_data;
        data_next.p = (in_data.hi ? c_hi : c_lo) + shifted[P_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule

[rtl/inverse_error_function.sv]
// Inverse error function, signed Q0.23 in, signed Q2.20 out.
// Accepts one transaction per cycle while the skid entry is empty: every stage
// (28 log cells, 31 sqrt cells, 8 Horner cells) is a separate registered
// cell with at most one multiplier.
// A one-entry skid behind the output register takes the next result while one
// waits. Async active-low reset empties the pipeline; no other state.
module inverse_error_function (
    input  logic               clk,
    input  logic               rst_n,
    erfinv_in_if.sink          arg_ch,
    erfinv_out_if.source       result_ch
);
    import erfinv_pkg::*;
    `include "assert_macros.svh"

    localparam int F   = IN_FRAC_BITS;
    localparam int FP_W = P_W + IN_W;
    localparam int FR_W = FP_W - SH_OUT;

    localparam logic [D_W-1:0]   D_ONE  = {1'b1, {(2*F){1'b0}}};
    localparam logic [V_W-1:0]   V_TOP  = V_W'(2 * F) << WFB;
    localparam logic [W_W-1:0]   W_FIVE = W_W'(5) << WFB;
    localparam logic signed [T_W-1:0] T_HALF5 = T_W'(5) <<< (WFB - 1);
    localparam logic signed [T_W-1:0] T_THREE = T_W'(3) <<< WFB;
    localparam logic signed [FP_W-1:0] F_RND = FP_W'(1) <<< (SH_OUT - 1);
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [FR_W-1:0] R_MAX = FR_W'(OUT_MAX);
    localparam logic signed [FR_W-1:0] R_MIN = FR_W'(OUT_MIN);

    typedef struct packed {
        logic signed [OUT_W-1:0] erfinv_value;
        logic                    saturated;
    } res_t;

    logic en;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic fire;

    assign en = !skid_valid_reg;
    assign arg_ch.ready = en;

    // front end
    logic [9:0] v_reg;   // s0..s9 valids (s3 feeds log chain, s6 sqrt, s7 horner)
    front_t f0_reg, f1_reg, f2_reg;
    logic [IN_W-1:0] ax0_reg;
    logic [D_W-1:0]  d1_reg, d2_reg;
    logic [E_W-1:0]  e2_reg;
    log_t            l3_reg;
    logic [E_W-1:0]  e_next;
    logic [D_W+M_W-2:0] norm;
    front_t          f_in;

    always_comb
    begin
        f_in.x    = arg_ch.arg_x;
        f_in.zero = arg_ch.arg_x == {1'b1, {(IN_W-1){1'b0}}};
        e_next = '0;
        for (int i = 0; i < D_W; i++)
        begin
            if (d1_reg[i])
                e_next = E_W'(i);
        end
        norm = {d2_reg, {(M_W-1){1'b0}}} >> e2_reg;
    end

    // log chain
    log_t            log_link [LOG_STEPS+1];
    logic [LOG_STEPS:0] log_v;
    assign log_link[0] = l3_reg;
    assign log_v[0]    = v_reg[3];

    genvar g;
    generate
        for (g = 0; g < LOG_STEPS; g++)
        begin : g_log
            erfinv_log_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .in_valid(log_v[g]), .in_data(log_link[g]),
                .out_valid(log_v[g+1]), .out_data(log_link[g+1])
            );
        end
    endgenerate

    front_t f4_reg, f5_reg;
    logic [V_W-1:0] v4_reg;
    logic [W_W-1:0] w5_reg;
    logic [V_W+29:0] wprod;
    logic [V_W+29:0] wsum;
    sqrt_t s6_reg, s6_next;

    always_comb
    begin
        wprod = v4_reg * LN2_Q30;
        wsum  = wprod + (V_W+30)'(30'd1 << 29);
        s6_next.n     = SQ_W'({w5_reg, {WFB{1'b0}}});
        s6_next.rem   = '0;
        s6_next.root  = '0;
        s6_next.hi    = !(w5_reg < W_FIVE);
        s6_next.t_lo  = $signed(T_W'(w5_reg)) - T_HALF5;
        s6_next.front = f5_reg;
    end

    // sqrt chain
    sqrt_t          sq_link [R_W+1];
    logic [R_W:0]   sq_v;
    assign sq_link[0] = s6_reg;
    assign sq_v[0]    = v_reg[6];

    generate
        for (g = 0; g < R_W; g++)
        begin : g_sqrt
            erfinv_sqrt_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .in_valid(sq_v[g]), .in_data(sq_link[g]),
                .out_valid(sq_v[g+1]), .out_data(sq_link[g+1])
            );
        end
    endgenerate

    horner_t h7_reg, h7_next;
    sqrt_t   sq_last;

    always_comb
    begin
        sq_last       = sq_link[R_W];
        h7_next.hi    = sq_last.hi;
        h7_next.front = sq_last.front;
        h7_next.t     = sq_last.hi ? $signed({1'b0, sq_last.root}) - T_THREE : sq_last.t_lo;
        h7_next.p     = sq_last.hi ? COEF_HI[HORNER_STEPS] : COEF_LO[HORNER_STEPS];
    end

    // Horner chain, highest coefficient first
    horner_t                h_link [HORNER_STEPS+1];
    logic [HORNER_STEPS:0]  h_v;
    assign h_link[0] = h7_reg;
    assign h_v[0]    = v_reg[7];

    generate
        for (g = 0; g < HORNER_STEPS; g++)
        begin : g_horner
            erfinv_horner_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .c_lo(COEF_LO[HORNER_STEPS-1-g]), .c_hi(COEF_HI[HORNER_STEPS-1-g]),
                .in_valid(h_v[g]), .in_data(h_link[g]),
                .out_valid(h_v[g+1]), .out_data(h_link[g+1])
            );
        end
    endgenerate

    horner_t h_last;
    logic signed [FP_W-1:0] fp8_reg, fp8_next;
    front_t  f8_reg;
    logic signed [FP_W-1:0] fadj;
    logic signed [FP_W-1:0] fsh;
    logic signed [FR_W-1:0] r;
    res_t    res9_reg, res9_next;

    always_comb
    begin
        h_last   = h_link[HORNER_STEPS];
        fp8_next = h_last.p * h_last.front.x;
        fadj = fp8_reg + F_RND - $signed({{(FP_W-1){1'b0}}, fp8_reg[FP_W-1]});
        fsh  = fadj >>> SH_OUT;
        r    = fsh[FR_W-1:0];
        if (f8_reg.zero)
        begin
            res9_next.erfinv_value = OUT_MIN;
            res9_next.saturated    = 1'b1;
        end
        else if (r > R_MAX)
        begin
            res9_next.erfinv_value = OUT_MAX;
            res9_next.saturated    = 1'b1;
        end
        else if (r < R_MIN)
        begin
            res9_next.erfinv_value = OUT_MIN;
            res9_next.saturated    = 1'b1;
        end
        else
        begin
            res9_next.erfinv_value = r[OUT_W-1:0];
            res9_next.saturated    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
        begin
            v_reg[0] <= arg_ch.valid;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= log_v[LOG_STEPS];
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= sq_v[R_W];
            v_reg[8] <= h_v[HORNER_STEPS];
            v_reg[9] <= v_reg[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_reg   <= f_in;
            ax0_reg  <= arg_ch.arg_x[IN_W-1] ? IN_W'(-arg_ch.arg_x) : IN_W'(arg_ch.arg_x);
            f1_reg   <= f0_reg;
            d1_reg   <= D_ONE - D_W'(ax0_reg * ax0_reg);
            f2_reg   <= f1_reg;
            d2_reg   <= d1_reg;
            e2_reg   <= e_next;
            l3_reg.e     <= e2_reg;
            l3_reg.m     <= norm[M_W-1:0];
            l3_reg.frac  <= '0;
            l3_reg.front <= f2_reg;
            f4_reg   <= log_link[LOG_STEPS].front;
            v4_reg   <= V_TOP - {log_link[LOG_STEPS].e, log_link[LOG_STEPS].frac};
            f5_reg   <= f4_reg;
            w5_reg   <= wsum[30 +: W_W];
            s6_reg   <= s6_next;
            h7_reg   <= h7_next;
            fp8_reg  <= fp8_next;
            f8_reg   <= h_last.front;
            res9_reg <= res9_next;
        end
    end

    // output register with one-entry skid
    always_comb
    begin
        fire            = out_valid_reg && result_ch.ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (en && v_reg[9])
        begin
            if (!out_valid_reg || fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res9_reg;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res9_reg;
            end
        end
        else if (skid_valid_reg && fire)
        begin
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else if (fire)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.erfinv_value = out_data_reg.erfinv_value;
    assign result_ch.saturated    = out_data_reg.saturated;

    `ERF_ASSERT(a_skid_needs_out, clk, rst_n, skid_valid_reg |-> out_valid_reg, "skid full while output empty")
    `ERF_ASSERT(a_sat_at_ends, clk, rst_n, out_valid_reg && out_data_reg.saturated |-> (out_data_reg.erfinv_value == OUT_MIN || out_data_reg.erfinv_value == OUT_MAX), "saturated result not at a range end")
    `ERF_ASSERT(a_stall_to_skid, clk, rst_n, en && v_reg[9] && out_valid_reg && !result_ch.ready |=> skid_valid_reg, "stalled result not captured in skid")
    `ERF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid_reg && !skid_valid_reg, "output not empty in reset")
endmodule

[sim/inverse_error_function_tb.sv]
// Self-checking testbench for the inverse_error_function pipeline.
// Depends on erfinv_pkg and the erfinv_in_if / erfinv_out_if interfaces.
// Directed table, then random arguments, checked against an in-bench predictor.
module inverse_error_function_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import erfinv_pkg::*;

    localparam int LATENCY = 78;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM = 800;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } erfinv_res_t;

    typedef struct {
        logic signed [IN_W-1:0] arg;
        logic                   known;   // expected result typed in below
        erfinv_res_t            res;
    } arg_row_t;

    logic clk;
    logic rst_n;

    erfinv_in_if  arg_ch();
    erfinv_out_if result_ch();

    inverse_error_function u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_ch    (arg_ch.sink),
        .result_ch (result_ch.source)
    );

    erfinv_res_t pending_q[$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    bit          no_gaps;      // long stretch with no idling on either side
    arg_row_t    directed[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint rnd_shift(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v < 0)
            return -((-v + half) >>> n);
        return (v + half) >>> n;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic erfinv_res_t predict_erfinv(logic signed [IN_W-1:0] arg);
        erfinv_res_t     res;
        longint          x;
        longint          t;
        longint          p;
        longint          r;
        longint unsigned ax;
        longint unsigned d;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned v;
        longint unsigned w;
        int              e;
        bit              hi;
        x = arg;
        ax = (x < 0) ? -x : x;
        d = (64'd1 << (2 * IN_FRAC_BITS)) - ax * ax;
        if (d == 0)
        begin
            res.value = {1'b1, {(OUT_W-1){1'b0}}};
            res.sat = 1'b1;
            return res;
        end
        e = 0;
        while ((d >> (e + 1)) != 0)
            e++;
        m = (e >= 30) ? d >> (e - 30) : d << (30 - e);
        frac = 0;
        for (int i = 0; i < WFB; i++)
        begin
            m = (m * m) >> 30;
            frac <<= 1;
            if (m >= (64'd1 << 31))
            begin
                frac |= 1;
                m >>= 1;
            end
        end
        v = (longint'(2 * IN_FRAC_BITS) << WFB) - ((longint'(e) << WFB) + frac);
        w = (v * 64'd744261118 + (64'd1 << 29)) >> 30;
        hi = (w >= (64'd5 << WFB));
        if (!hi)
            t = longint'(w) - (longint'(5) << (WFB - 1));
        else
            t = longint'(int_sqrt(w << WFB)) - (longint'(3) << WFB);
        p = hi ? COEF_HI[8] : COEF_LO[8];
        for (int k = 7; k >= 0; k--)
            p = (hi ? longint'(COEF_HI[k]) : longint'(COEF_LO[k])) + rnd_shift(p * t, WFB);
        r = rnd_shift(p * x, SH_OUT);
        res.sat = 1'b0;
        if (r > (longint'(1) << (OUT_W - 1)) - 1)
        begin
            r = (longint'(1) << (OUT_W - 1)) - 1;
            res.sat = 1'b1;
        end
        else if (r < -(longint'(1) << (OUT_W - 1)))
        begin
            r = -(longint'(1) << (OUT_W - 1));
            res.sat = 1'b1;
        end
        res.value = r[OUT_W-1:0];
        return res;
    endfunction

    function automatic logic idle_now();
        return !no_gaps && ($urandom_range(99) < 28);
    endfunction

    // valid stays high after acceptance; the caller drops it after the last one
    task automatic send_arg(logic signed [IN_W-1:0] arg, bit known, erfinv_res_t typed);
        erfinv_res_t exp_res;
        exp_res = predict_erfinv(arg);
        if (known && exp_res !== typed)
            $display("note: typed result for %0d differs from predictor", arg);
        while (idle_now())
        begin
            arg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        arg_ch.valid <= 1'b1;
        arg_ch.arg_x <= arg;
        do
            @(posedge clk);
        while (!arg_ch.ready);
        if (known)
            exp_res = typed;
        pending_q.insert(pending_q.size(), exp_res);
    endtask

    task automatic add_row(logic signed [IN_W-1:0] arg, bit known, erfinv_res_t res);
        arg_row_t row;
        row.arg = arg;
        row.known = known;
        row.res = res;
        directed.insert(directed.size(), row);
    endtask

    // result sink with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !idle_now();
    end

    // result checker
    always @(posedge clk)
    begin
        erfinv_res_t got;
        erfinv_res_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.value = result_ch.erfinv_value;
            got.sat = result_ch.saturated;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: value %0d sat %0b", got.value, got.sat);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.value !== want.value || got.sat !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value exp %0d got %0d, sat exp %0b got %0b",
                                 want.value, got.value, want.sat, got.sat);
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((arg_ch.valid && arg_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        erfinv_res_t none;
        erfinv_res_t r;
        int          mag;
        bit          neg;
        logic signed [IN_W-1:0] a;
        none = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        arg_ch.valid = 1'b0;
        arg_ch.arg_x = '0;

        // minus one saturates to the most negative code
        r.value = {1'b1, {(OUT_W-1){1'b0}}};
        r.sat = 1'b1;
        add_row(-24'sd8388608, 1'b1, r);
        r = '0;
        add_row(24'sd0, 1'b1, r);
        add_row(24'sd8388607, 1'b0, none);
        add_row(-24'sd8388607, 1'b0, none);
        add_row(24'sd1, 1'b0, none);
        add_row(-24'sd1, 1'b0, none);
        add_row(24'sd4194304, 1'b0, none);
        add_row(-24'sd4194304, 1'b0, none);
        add_row(24'sd8300000, 1'b0, none);   // near the w = 5 branch switch
        add_row(24'sd8310000, 1'b0, none);
        add_row(24'sd8320000, 1'b0, none);
        add_row(-24'sd8315000, 1'b0, none);
        add_row(24'sd8388000, 1'b0, none);
        add_row(24'sd5592405, 1'b0, none);
        add_row(24'h555555, 1'b0, none);
        add_row(24'shAAAAAA, 1'b0, none);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            begin
                foreach (directed[i])
                    send_arg(directed[i].arg, directed[i].known, directed[i].res);
                arg_ch.valid <= 1'b0;
                // hold off until the pipeline drains once
                while (pending_q.size() != 0)
                    @(posedge clk);
                for (int n = 0; n < N_RANDOM; n++)
                begin
                    no_gaps = (n >= 300 && n < 420);
                    neg = ($urandom_range(1) == 1);
                    case ($urandom_range(3))
                        0: a = IN_W'($urandom);
                        1:
                        begin
                            mag = 8388607 - int'($urandom_range(20000));
                            a = IN_W'(neg ? -mag : mag);
                        end
                        2:
                        begin
                            mag = int'($urandom_range(8388607, 8250000));
                            a = IN_W'(neg ? -mag : mag);
                        end
                        default:
                        begin
                            mag = int'($urandom_range(65535));
                            a = IN_W'(neg ? -mag : mag);
                        end
                    endcase
                    send_arg(a, 1'b0, none);
                end
                arg_ch.valid <= 1'b0;
                no_gaps = 1'b0;
                while (pending_q.size() != 0)
                    @(posedge clk);
                repeat (LATENCY + 10) @(posedge clk);
            end
            begin
                while (idle_cycles < WATCHDOG_LIMIT)
                    @(posedge clk);
                timed_out = 1'b1;
            end
        join_any

        if (timed_out || mismatches != 0 || pending_q.size() != 0)
            $display("inverse_error_function_tb: errors");
        else
            $display("inverse_error_function_tb: clean");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/erfinv_pkg.sv
rtl/erfinv_if.sv
rtl/erfinv_log_cell.sv
rtl/erfinv_sqrt_cell.sv
rtl/erfinv_horner_cell.sv
rtl/inverse_error_function.sv
sim/inverse_error_function_tb.sv
